// ----- src/sac_pkg.sv -----
// Shared types and constants for the stick axis conditioner.
// Holds the word structs, the calibration layout, the state enum and reset values.
// Depends on nothing; every other file imports it.
package sac_pkg;

  localparam int NUM_AXES     = 4;
  localparam int NUM_SWITCHES = 3;
  localparam int CAL_COUNT    = 4;

  localparam int SMP_W  = 12;
  localparam int IDX_W  = 2;
  localparam int CHAN_W = 3;
  localparam int PW_W   = 11;
  localparam int CAL_W  = 38;

  localparam int DEADBAND    = 15;
  localparam int OUT_LOW     = 1000;
  localparam int OUT_MID     = 1500;
  localparam int OUT_HIGH    = 2000;
  localparam int INVERT_BASE = 3000;

  // The smoother (8*old + 2*new)/10 is computed as (4*old + new)/5.
  localparam int FILT_OLD_WEIGHT = 8;
  localparam int FILT_NEW_WEIGHT = 2;
  localparam int FILT_DENOM      = 10;
  localparam int FILT_DIVISOR    = FILT_DENOM / FILT_NEW_WEIGHT;
  localparam int FILT_OLD_SHIFT  = $clog2(FILT_OLD_WEIGHT / FILT_NEW_WEIGHT);

  // Serial divider: the upper half of the dividend must be below the divisor.
  localparam int DIV_W     = 12;
  localparam int DIVD_W    = 2 * DIV_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic KIND_AXIS   = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] channel_index;
    logic [SMP_W-1:0] sample;
    logic             switch_low;
  } sac_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [PW_W-1:0]   pulse_width;
  } sac_out_t;

  typedef struct packed {
    logic             invert;
    logic             centered;
    logic [SMP_W-1:0] max_val;
    logic [SMP_W-1:0] mid_val;
    logic [SMP_W-1:0] min_val;
  } sac_cal_t;

  typedef sac_cal_t sac_cal_arr_t [CAL_COUNT];

  localparam sac_cal_arr_t CAL_RESET = '{
    '{invert: 1'b1, centered: 1'b1, max_val: 12'd3900, mid_val: 12'd2048, min_val: 12'd200},
    '{invert: 1'b1, centered: 1'b1, max_val: 12'd3900, mid_val: 12'd2048, min_val: 12'd200},
    '{invert: 1'b0, centered: 1'b1, max_val: 12'd3900, mid_val: 12'd2048, min_val: 12'd200},
    '{invert: 1'b0, centered: 1'b0, max_val: 12'd3900, mid_val: 12'd2048, min_val: 12'd200}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_MAP,
    ST_SLOPE,
    ST_OUT
  } sac_state_e;

endpackage

// ----- src/sac_cal_regs.sv -----
// Calibration register file, one packed word per axis, written from the config port.
// Depends on sac_pkg for the calibration layout and reset values.
module sac_cal_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [sac_pkg::IDX_W-1:0] wr_index_i,
  input  logic [sac_pkg::CAL_W-1:0] wr_data_i,
  input  logic [sac_pkg::IDX_W-1:0] rd_index_i,
  output sac_pkg::sac_cal_t         rd_cal_o
);
  import sac_pkg::*;

  sac_cal_t cal_q [CAL_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAL_COUNT; i++) begin
        cal_q[i] <= CAL_RESET[i];
      end
    end else if (we_i) begin
      cal_q[wr_index_i] <= sac_cal_t'(wr_data_i);
    end
  end

  assign rd_cal_o = cal_q[rd_index_i];

endmodule

// ----- src/sac_serial_div.sv -----
// Restoring divider that retires one quotient bit per cycle.
// Depends on sac_pkg for its widths; the dividend's upper half must be below the divisor.
module sac_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sac_pkg::DIVD_W-1:0] dividend_i,
  input  logic [sac_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [sac_pkg::DIV_W-1:0]  quotient_o
);
  import sac_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     sh_q, sh_d;
  logic [DIV_W-1:0]     dsr_q, dsr_d;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  assign trial = {rem_q, sh_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = dividend_i[DIVD_W-1:DIV_W];
      sh_d  = dividend_i[DIV_W-1:0];
      dsr_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      sh_d  = {sh_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// ----- src/stick_axis_conditioner.sv -----
// Top level of the stick axis conditioner: sequencer, smoother store and output register.
// Depends on sac_pkg, sac_cal_regs and sac_serial_div.
//
// A switch word passes through ST_OUT into the output register. An axis word passes
// ST_FILT, a pass of the shared bit-serial divider for the smoother (it retires twelve
// quotient bits, then raises its done flag; skipped while the axis's stored value is
// zero), ST_MAP for the range checks, ST_SLOPE with a second divider pass for the slope
// (skipped at the clamps, in the deadband and for a zero span), and ST_OUT to load the
// result. One word is in work at a time; the next word is taken once the sequencer is
// back in ST_IDLE after the output register loads.
// A new word is taken while the previous result still waits; a stalled output holds the
// sequencer until the output register frees.
module stick_axis_conditioner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sac_pkg::sac_in_t          in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sac_pkg::sac_out_t         out_word_o,
  input  logic                      cfg_we_i,
  input  logic [sac_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [sac_pkg::CAL_W-1:0] cfg_wdata_i
);
  import sac_pkg::*;

  sac_state_e        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SMP_W-1:0]  filt_q, filt_d;
  logic [PW_W-1:0]   res_q, res_d;
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic              axis_q, axis_d;
  logic              base_hi_q, base_hi_d;
  logic [SMP_W-1:0]  store_q [CAL_COUNT];
  logic              out_valid_q;
  sac_out_t          out_word_q;

  sac_cal_t          cal;
  logic              in_acc;
  logic [SMP_W-1:0]  old_val;
  logic [SMP_W+2:0]  filt_sum;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic              store_we;
  logic              out_load;
  logic [PW_W-1:0]   res_final;
  logic [SMP_W:0]    v13, mid13;
  logic              le_lo, ge_hi, in_band, below_mid;
  logic [SMP_W-1:0]  offset, span_range;
  logic              span_full, use_mid_base;
  logic [21:0]       prod500;
  logic [21:0]       prod;

  sac_cal_regs u_cal_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (cfg_we_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_wdata_i),
    .rd_index_i (idx_q),
    .rd_cal_o   (cal)
  );

  sac_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign old_val  = store_q[in_word_i.channel_index];
  assign filt_sum = (SMP_W+3)'({old_val, FILT_OLD_SHIFT'(0)}) + (SMP_W+3)'(in_word_i.sample);

  assign v13       = {1'b0, filt_q};
  assign mid13     = {1'b0, cal.mid_val};
  assign le_lo     = (filt_q <= cal.min_val);
  assign ge_hi     = (filt_q >= cal.max_val);
  assign in_band   = cal.centered && (v13 + (SMP_W+1)'(DEADBAND) >= mid13)
                     && (v13 <= mid13 + (SMP_W+1)'(DEADBAND));
  assign below_mid = (filt_q < cal.mid_val);

  always_comb begin
    span_full    = 1'b0;
    use_mid_base = 1'b0;
    offset       = filt_q - cal.min_val;
    span_range   = cal.mid_val - cal.min_val;
    if (!cal.centered) begin
      span_full  = 1'b1;
      span_range = cal.max_val - cal.min_val;
    end else if (!below_mid) begin
      use_mid_base = 1'b1;
      offset       = filt_q - cal.mid_val;
      span_range   = cal.max_val - cal.mid_val;
    end
  end

  // The span is 500 or 1000; offset * 500 is built from shifts.
  assign prod500 = (22'(offset) << 9) - (22'(offset) << 3) - (22'(offset) << 2);
  assign prod    = span_full ? {prod500[20:0], 1'b0} : prod500;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    filt_d       = filt_q;
    res_d        = res_q;
    chan_d       = chan_q;
    axis_d       = axis_q;
    base_hi_d    = base_hi_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    store_we     = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = in_word_i.channel_index;
          if (in_word_i.kind == KIND_SWITCH) begin
            if (int'(in_word_i.channel_index) < NUM_SWITCHES) begin
              res_d   = in_word_i.switch_low ? PW_W'(OUT_HIGH) : PW_W'(OUT_LOW);
              chan_d  = CHAN_W'(NUM_AXES) + CHAN_W'(in_word_i.channel_index);
              axis_d  = 1'b0;
              state_d = ST_OUT;
            end
          end else if (int'(in_word_i.channel_index) < NUM_AXES &&
                       int'(in_word_i.channel_index) < CAL_COUNT) begin
            chan_d = CHAN_W'(in_word_i.channel_index);
            axis_d = 1'b1;
            if (old_val == '0) begin
              filt_d  = in_word_i.sample;
              state_d = ST_MAP;
            end else begin
              div_start    = 1'b1;
              div_dividend = DIVD_W'(filt_sum);
              div_divisor  = DIV_W'(FILT_DIVISOR);
              state_d      = ST_FILT;
            end
          end
        end
      end
      ST_FILT: begin
        if (div_done) begin
          filt_d  = div_quot;
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        store_we = 1'b1;
        state_d  = ST_OUT;
        priority if (le_lo) begin
          res_d = PW_W'(OUT_LOW);
        end else if (ge_hi) begin
          res_d = PW_W'(OUT_HIGH);
        end else if (in_band) begin
          res_d = PW_W'(OUT_MID);
        end else if (span_range == '0) begin
          res_d = PW_W'(OUT_HIGH);
        end else begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(prod);
          div_divisor  = span_range;
          base_hi_d    = use_mid_base;
          state_d      = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (div_done) begin
          res_d   = (base_hi_q ? PW_W'(OUT_MID) : PW_W'(OUT_LOW)) + div_quot[PW_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [PW_W:0] inverted;
    inverted  = (PW_W+1)'(INVERT_BASE) - {1'b0, res_q};
    res_final = (axis_q && cal.invert) ? inverted[PW_W-1:0] : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CAL_COUNT; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (store_we) begin
        store_q[idx_q] <= filt_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    filt_q    <= filt_d;
    res_q     <= res_d;
    chan_q    <= chan_d;
    axis_q    <= axis_d;
    base_hi_q <= base_hi_d;
    if (out_load) begin
      out_word_q.channel     <= chan_q;
      out_word_q.pulse_width <= res_final;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- src/sac_checker.sv -----
// Port-level checks for the stick axis conditioner, attached by the bind at the end.
// Depends on sac_pkg for the word structs and channel counts.
module sac_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input sac_pkg::sac_in_t          in_word_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input sac_pkg::sac_out_t         out_word_o
);
  import sac_pkg::*;

  pw_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.pulse_width >= PW_W'(OUT_LOW)) &&
                    (out_word_o.pulse_width <= PW_W'(OUT_HIGH)))
    else $error("Pulse width left the 1000 to 2000 range.");

  switch_level_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (int'(out_word_o.channel) >= NUM_AXES)) |->
      (out_word_o.pulse_width == PW_W'(OUT_LOW) || out_word_o.pulse_width == PW_W'(OUT_HIGH)))
    else $error("A switch word carried a level other than 1000 or 2000.");

  chan_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_word_o.channel) < NUM_AXES + NUM_SWITCHES))
    else $error("Output channel beyond the last switch.");

  switch_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.kind == KIND_SWITCH &&
     int'(in_word_i.channel_index) < NUM_SWITCHES) |=> in_stall_o)
    else $error("A valid switch word did not occupy the block.");

  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("A stalled output word changed or vanished.");

endmodule

bind stick_axis_conditioner sac_checker u_sac_checker (.*);
